// ----- sv/assert_macros.svh -----
// Assertion macros shared by the checker files of this block.
// No dependencies; included by the files that hold concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define SCPR_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define SCPR_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ----- sv/scpr_pkg.sv -----
// Package for the second chance page replacement block.
// Holds default sizes, fixed field widths and the cell link and command structs.
`default_nettype none

package scpr_pkg;

    localparam int FRAMES_DEF    = 16;
    localparam int PAGE_BITS_DEF = 20;
    localparam int CFG_BITS      = 5;
    localparam int CNT_BITS      = 32;
    localparam int FRAME_BITS    = 4;
    localparam logic [CFG_BITS-1:0] CFG_RESET = 5'd16;

    typedef struct packed {
        logic hit_seen;
        logic pick_seen;
    } scpr_link_t;

    typedef struct packed {
        logic active;
        logic in_range;
        logic fill_sel;
        logic first;
    } scpr_slot_t;

    typedef struct packed {
        logic update;
        logic any_hit;
        logic evict;
        logic none_pick;
    } scpr_cmd_t;

endpackage

`default_nettype wire

// ----- sv/scpr_cell.sv -----
// One page frame cell: stored page, used bit, tag compare and victim scan link.
// Depends on scpr_pkg for the link, slot and command structs.
`default_nettype none

module scpr_cell #(
    parameter int PAGE_BITS = scpr_pkg::PAGE_BITS_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire scpr_pkg::scpr_cmd_t  cmd,
    input  wire scpr_pkg::scpr_slot_t slot,
    input  wire logic [PAGE_BITS-1:0] req_page,
    input  wire scpr_pkg::scpr_link_t link_in,
    output scpr_pkg::scpr_link_t      link_out,
    input  wire logic [PAGE_BITS-1:0] page_in,
    output logic      [PAGE_BITS-1:0] page_out,
    output logic                      hit_first,
    output logic                      pick_here
);
    import scpr_pkg::*;

    logic [PAGE_BITS-1:0] page_reg;
    logic [PAGE_BITS-1:0] page_next;
    logic                 used_reg;
    logic                 used_next;
    logic                 match;
    logic                 victim;

    always_comb
    begin
        match              = slot.active && (page_reg == req_page);
        hit_first          = match && !link_in.hit_seen;
        pick_here          = slot.in_range && !used_reg && !link_in.pick_seen;
        link_out.hit_seen  = link_in.hit_seen | match;
        link_out.pick_seen = link_in.pick_seen | pick_here;
        victim             = pick_here || (slot.first && cmd.none_pick);
        page_out           = victim ? page_reg : page_in;

        used_next = used_reg;
        page_next = page_reg;
        if (cmd.update)
        begin
            if (cmd.any_hit)
            begin
                if (match)
                begin
                    used_next = 1'b1;
                end
            end
            else if (!cmd.evict)
            begin
                if (slot.fill_sel)
                begin
                    page_next = req_page;
                    used_next = 1'b0;
                end
            end
            else
            begin
                if (slot.in_range && !link_in.pick_seen)
                begin
                    used_next = 1'b0;
                end
                if (victim)
                begin
                    page_next = req_page;
                    used_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= 1'b0;
        end
        else
        begin
            used_reg <= used_next;
        end
    end

    always_ff @(posedge clk)
    begin
        page_reg <= page_next;
    end

endmodule

`default_nettype wire

// ----- sv/second_chance_page_replacement.sv -----
// Top level of the second chance page replacement block: a row of frame cells,
// request register, fill count, saturating counters. Depends on scpr_pkg, scpr_cell.
//
//   channel   handshake              payload
//   request   start / busy           request_page
//   result    done (one-cycle strobe) hit, frame, evicted, evicted_page,
//                                    hit_count, requests_seen
//   config    wr_en                  frames_in_use
//
// For each item, the accepting edge loads the request register, and
// the next edge applies the cell row's compare and victim scan and registers the result.
// A new item may be accepted in the cycle that the result strobe is shown.
// Reset clears the used bits, the fill count and both counters; no clearing pass.
// The receiver cannot stall, so results never wait.
`default_nettype none

module second_chance_page_replacement #(
    parameter int FRAMES    = scpr_pkg::FRAMES_DEF,
    parameter int PAGE_BITS = scpr_pkg::PAGE_BITS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire logic [PAGE_BITS-1:0]            request_page,
    input  wire logic                            wr_en,
    input  wire logic [scpr_pkg::CFG_BITS-1:0]   frames_in_use,
    output logic                                 done,
    output logic                                 hit,
    output logic      [scpr_pkg::FRAME_BITS-1:0] frame,
    output logic                                 evicted,
    output logic      [PAGE_BITS-1:0]            evicted_page,
    output logic      [scpr_pkg::CNT_BITS-1:0]   hit_count,
    output logic      [scpr_pkg::CNT_BITS-1:0]   requests_seen
);
    import scpr_pkg::*;

    localparam int CNT_W = $clog2(FRAMES + 1);
    localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int CW    = (CNT_W > CFG_BITS) ? CNT_W : CFG_BITS;

    logic [CFG_BITS-1:0]   cfg_reg;
    logic [CNT_W-1:0]      filled_reg;
    logic [CNT_W-1:0]      filled_next;
    logic [PAGE_BITS-1:0]  req_reg;
    logic                  busy_reg;
    logic                  done_reg;
    logic                  hit_reg;
    logic [FRAME_BITS-1:0] frame_reg;
    logic [FRAME_BITS-1:0] frame_next;
    logic                  evicted_reg;
    logic [PAGE_BITS-1:0]  evicted_page_reg;
    logic [PAGE_BITS-1:0]  evicted_page_next;
    logic [CNT_BITS-1:0]   hit_total_reg;
    logic [CNT_BITS-1:0]   hit_total_next;
    logic [CNT_BITS-1:0]   request_total_reg;
    logic [CNT_BITS-1:0]   request_total_next;

    logic [CW-1:0]         cfg_ext;
    logic [CNT_W-1:0]      n_act;
    logic [CNT_W-1:0]      lim;
    logic                  full;
    logic                  any_hit;
    logic [IDX_W-1:0]      hit_idx;
    logic [IDX_W-1:0]      pick_idx;
    logic [IDX_W-1:0]      frame_idx;
    logic [IDX_W+FRAME_BITS-1:0] frame_wide;

    scpr_cmd_t             cmd;
    scpr_slot_t            slot  [FRAMES];
    scpr_link_t            link  [FRAMES+1];
    logic [PAGE_BITS-1:0]  pchain [FRAMES+1];
    logic [FRAMES-1:0]     hit_first;
    logic [FRAMES-1:0]     pick_here;

    always_comb
    begin
        cfg_ext = CW'(cfg_reg);
        if (cfg_ext == '0)
        begin
            n_act = CNT_W'(1);
        end
        else if (cfg_ext > CW'(FRAMES))
        begin
            n_act = CNT_W'(FRAMES);
        end
        else
        begin
            n_act = CNT_W'(cfg_ext);
        end
        lim  = (filled_reg < n_act) ? filled_reg : n_act;
        full = (filled_reg >= n_act);
    end

    assign link[0]   = '0;
    assign pchain[0] = '0;

    for (genvar i = 0; i < FRAMES; i++)
    begin : g_cell
        assign slot[i].active   = (CNT_W'(i) < lim);
        assign slot[i].in_range = (CNT_W'(i) < n_act);
        assign slot[i].fill_sel = (CNT_W'(i) == filled_reg);
        assign slot[i].first    = (i == 0);

        scpr_cell #(
            .PAGE_BITS(PAGE_BITS)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .cmd      (cmd),
            .slot     (slot[i]),
            .req_page (req_reg),
            .link_in  (link[i]),
            .link_out (link[i+1]),
            .page_in  (pchain[i]),
            .page_out (pchain[i+1]),
            .hit_first(hit_first[i]),
            .pick_here(pick_here[i])
        );
    end

    always_comb
    begin
        any_hit       = link[FRAMES].hit_seen;
        cmd.update    = busy_reg;
        cmd.any_hit   = any_hit;
        cmd.evict     = !any_hit && full;
        cmd.none_pick = !link[FRAMES].pick_seen;

        hit_idx  = '0;
        pick_idx = '0;
        for (int i = 0; i < FRAMES; i++)
        begin
            if (hit_first[i])
            begin
                hit_idx = hit_idx | IDX_W'(i);
            end
            if (pick_here[i])
            begin
                pick_idx = pick_idx | IDX_W'(i);
            end
        end

        filled_next       = filled_reg;
        evicted_page_next = '0;
        if (any_hit)
        begin
            frame_idx = hit_idx;
        end
        else if (!full)
        begin
            frame_idx   = filled_reg[IDX_W-1:0];
            filled_next = filled_reg + CNT_W'(1);
        end
        else
        begin
            frame_idx         = cmd.none_pick ? '0 : pick_idx;
            evicted_page_next = pchain[FRAMES];
        end
        frame_wide = {{FRAME_BITS{1'b0}}, frame_idx};
        frame_next = frame_wide[FRAME_BITS-1:0];

        hit_total_next = hit_total_reg;
        if (any_hit && (hit_total_reg != '1))
        begin
            hit_total_next = hit_total_reg + CNT_BITS'(1);
        end
        request_total_next = request_total_reg;
        if (request_total_reg != '1)
        begin
            request_total_next = request_total_reg + CNT_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg           <= CFG_RESET;
            filled_reg        <= '0;
            busy_reg          <= 1'b0;
            done_reg          <= 1'b0;
            hit_total_reg     <= '0;
            request_total_reg <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                cfg_reg <= frames_in_use;
            end
            done_reg <= busy_reg;
            if (busy_reg)
            begin
                busy_reg          <= 1'b0;
                filled_reg        <= filled_next;
                hit_total_reg     <= hit_total_next;
                request_total_reg <= request_total_next;
            end
            else if (start)
            begin
                busy_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy_reg)
        begin
            req_reg <= request_page;
        end
        if (busy_reg)
        begin
            hit_reg          <= any_hit;
            frame_reg        <= frame_next;
            evicted_reg      <= cmd.evict;
            evicted_page_reg <= evicted_page_next;
        end
    end

    assign busy          = busy_reg;
    assign done          = done_reg;
    assign hit           = hit_reg;
    assign frame         = frame_reg;
    assign evicted       = evicted_reg;
    assign evicted_page  = evicted_page_reg;
    assign hit_count     = hit_total_reg;
    assign requests_seen = request_total_reg;

endmodule

`default_nettype wire

// ----- sv/scpr_checker.sv -----
// Port-level checker for the second chance page replacement block, with its bind.
// Depends on assert_macros.svh and scpr_pkg.
`default_nettype none

`include "assert_macros.svh"

module scpr_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          start,
    input wire logic                          busy,
    input wire logic                          done,
    input wire logic                          hit,
    input wire logic                          evicted,
    input wire logic [scpr_pkg::CNT_BITS-1:0] requests_seen
);
    import scpr_pkg::*;

    // An accepted item keeps the block busy for the next cycle.
    `SCPR_ASSERT_NXT(a_accept_busy, clk, rst_n, start && !busy, busy)
    // A busy cycle is followed by exactly one result and the block is free again.
    `SCPR_ASSERT_NXT(a_busy_done, clk, rst_n, busy, done && !busy)
    // A result is only shown after a busy cycle, so only for an accepted item.
    `SCPR_ASSERT_IMP(a_done_origin, clk, rst_n, done, $past(busy))
    // A hit never replaces a resident page.
    `SCPR_ASSERT_IMP(a_hit_no_evict, clk, rst_n, done && evicted, !hit)
    // Every result counts at least one request.
    `SCPR_ASSERT_IMP(a_count_nonzero, clk, rst_n, done, requests_seen != '0)

endmodule

bind second_chance_page_replacement scpr_checker u_scpr_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .done         (done),
    .hit          (hit),
    .evicted      (evicted),
    .requests_seen(requests_seen)
);

`default_nettype wire

// ----- bench/page_replacement_checker.sv -----
// Checker for the second chance page replacement block: it watches the request,
// result and configuration ports, predicts each result and compares it field by field.
// Depends on scpr_pkg for the port widths and the reset value of the frame limit.

module page_replacement_checker (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    input  wire logic                            busy,
    input  wire logic [scpr_pkg::PAGE_BITS_DEF-1:0] request_page,
    input  wire logic                            wr_en,
    input  wire logic [scpr_pkg::CFG_BITS-1:0]   frames_in_use,
    input  wire logic                            done,
    input  wire logic                            hit,
    input  wire logic [scpr_pkg::FRAME_BITS-1:0] frame,
    input  wire logic                            evicted,
    input  wire logic [scpr_pkg::PAGE_BITS_DEF-1:0] evicted_page,
    input  wire logic [scpr_pkg::CNT_BITS-1:0]   hit_count,
    input  wire logic [scpr_pkg::CNT_BITS-1:0]   requests_seen,
    output int                                   fail_total,
    output int                                   outstanding,
    output int                                   results_checked,
    output int                                   hit_results,
    output int                                   evict_results
);

    localparam int NFRAMES = scpr_pkg::FRAMES_DEF;
    localparam int PBITS   = scpr_pkg::PAGE_BITS_DEF;

    typedef struct packed {
        logic                            hit;
        logic [scpr_pkg::FRAME_BITS-1:0] frame;
        logic                            evicted;
        logic [PBITS-1:0]                evicted_page;
        logic [scpr_pkg::CNT_BITS-1:0]   hit_count;
        logic [scpr_pkg::CNT_BITS-1:0]   requests_seen;
    } access_result_t;

    logic [PBITS-1:0]              resident_page [NFRAMES];
    logic                          used_mark [NFRAMES];
    int unsigned                   frames_filled;
    logic [scpr_pkg::CNT_BITS-1:0] hit_tally;
    logic [scpr_pkg::CNT_BITS-1:0] request_tally;
    logic [scpr_pkg::CFG_BITS-1:0] frame_limit_cfg;
    access_result_t                awaited_results [$];

    function automatic access_result_t predict_access(logic [PBITS-1:0] pg);
        access_result_t r;
        int unsigned    n;
        int unsigned    lim;
        int unsigned    victim;
        int unsigned    i;
        bit             found;
        r = '0;
        n = 32'(frame_limit_cfg);
        if (n == 0)
            n = 1;
        if (n > NFRAMES)
            n = NFRAMES;
        lim = (frames_filled < n) ? frames_filled : n;
        for (i = 0; i < lim; i++)
        begin
            if (resident_page[i] == pg)
            begin
                if (!r.hit)
                    r.frame = 4'(i);
                r.hit = 1'b1;
                used_mark[i] = 1'b1;
            end
        end
        if (!r.hit)
        begin
            if (frames_filled < n)
            begin
                victim = frames_filled;
                frames_filled++;
            end
            else
            begin
                victim = 0;
                found = 1'b0;
                for (i = 0; i < n && !found; i++)
                begin
                    if (!used_mark[i])
                    begin
                        victim = i;
                        found = 1'b1;
                    end
                    else
                    begin
                        used_mark[i] = 1'b0;
                    end
                end
                r.evicted = 1'b1;
                r.evicted_page = resident_page[victim];
            end
            r.frame = 4'(victim);
            resident_page[victim] = pg;
            used_mark[victim] = 1'b0;
        end
        else if (hit_tally != '1)
        begin
            hit_tally++;
        end
        if (request_tally != '1)
            request_tally++;
        r.hit_count = hit_tally;
        r.requests_seen = request_tally;
        return r;
    endfunction

    function automatic bit field_differs(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        access_result_t want;
        int             k;
        if (!rst_n)
        begin
            for (k = 0; k < NFRAMES; k++)
            begin
                resident_page[k] = '0;
                used_mark[k] = 1'b0;
            end
            frames_filled = 0;
            hit_tally = '0;
            request_tally = '0;
            frame_limit_cfg = scpr_pkg::CFG_RESET;
            awaited_results.delete();
            fail_total = 0;
            outstanding = 0;
            results_checked = 0;
            hit_results = 0;
            evict_results = 0;
        end
        else
        begin
            if (done)
            begin
                if (awaited_results.size() == 0)
                begin
                    fail_total++;
                    $display("%0t: result with no request pending, expected none,", $time);
                    $display("    actual hit=%0b frame=%0d", hit, frame);
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (field_differs("hit", 32'(want.hit), 32'(hit)))
                        fail_total++;
                    if (field_differs("frame", 32'(want.frame), 32'(frame)))
                        fail_total++;
                    if (field_differs("evicted", 32'(want.evicted), 32'(evicted)))
                        fail_total++;
                    if (field_differs("evicted_page", 32'(want.evicted_page),
                                      32'(evicted_page)))
                        fail_total++;
                    if (field_differs("hit_count", want.hit_count, hit_count))
                        fail_total++;
                    if (field_differs("requests_seen", want.requests_seen, requests_seen))
                        fail_total++;
                end
                results_checked++;
                if (hit)
                    hit_results++;
                if (evicted)
                    evict_results++;
            end
            if (wr_en)
                frame_limit_cfg = frames_in_use;
            if (start && !busy)
                awaited_results.push_back(predict_access(request_page));
            outstanding = awaited_results.size();
        end
    end

endmodule

// ----- bench/tb.sv -----
// Top of the testbench for the second chance page replacement block: clock, reset,
// request stimulus and frame limit writes. Depends on scpr_pkg, the block and the checker.

module tb;

    localparam int PBITS    = scpr_pkg::PAGE_BITS_DEF;
    localparam int PAGE_MAX = (1 << PBITS) - 1;

    logic                            clk;
    logic                            rst_n;
    logic                            start;
    logic                            busy;
    logic [PBITS-1:0]                request_page;
    logic                            wr_en;
    logic [scpr_pkg::CFG_BITS-1:0]   frames_in_use;
    logic                            done;
    logic                            hit;
    logic [scpr_pkg::FRAME_BITS-1:0] frame;
    logic                            evicted;
    logic [PBITS-1:0]                evicted_page;
    logic [scpr_pkg::CNT_BITS-1:0]   hit_count;
    logic [scpr_pkg::CNT_BITS-1:0]   requests_seen;

    int fail_total;
    int outstanding;
    int results_checked;
    int hit_results;
    int evict_results;
    int items_sent;
    int limit_writes;

    second_chance_page_replacement dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .request_page  (request_page),
        .wr_en         (wr_en),
        .frames_in_use (frames_in_use),
        .done          (done),
        .hit           (hit),
        .frame         (frame),
        .evicted       (evicted),
        .evicted_page  (evicted_page),
        .hit_count     (hit_count),
        .requests_seen (requests_seen)
    );

    page_replacement_checker page_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .request_page    (request_page),
        .wr_en           (wr_en),
        .frames_in_use   (frames_in_use),
        .done            (done),
        .hit             (hit),
        .frame           (frame),
        .evicted         (evicted),
        .evicted_page    (evicted_page),
        .hit_count       (hit_count),
        .requests_seen   (requests_seen),
        .fail_total      (fail_total),
        .outstanding     (outstanding),
        .results_checked (results_checked),
        .hit_results     (hit_results),
        .evict_results   (evict_results)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("FAIL");
        $finish;
    end

    function automatic int draw_gap();
        return $urandom_range(0, 17);
    endfunction

    task automatic send_page(input logic [PBITS-1:0] pg, input int gap);
        start <= 1'b1;
        request_page <= pg;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        items_sent++;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain_results();
        start <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_frames(input logic [scpr_pkg::CFG_BITS-1:0] value);
        wr_en <= 1'b1;
        frames_in_use <= value;
        @(posedge clk);
        wr_en <= 1'b0;
        limit_writes++;
        @(posedge clk);
    endtask

    initial
    begin
        int               phase_limits [8];
        logic [PBITS-1:0] working_set [24];
        logic [PBITS-1:0] pg;
        int               ph;
        int               it;
        int               k;
        int               span;
        int               roll;
        int               gap;

        phase_limits = '{16, 1, 7, 31, 0, 3, 12, 16};
        items_sent = 0;
        limit_writes = 0;
        rst_n <= 1'b0;
        start <= 1'b0;
        request_page <= '0;
        wr_en <= 1'b0;
        frames_in_use <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Fill four frames, mark two, then force a second chance scan and a full wrap.
        write_frames(5'd4);
        send_page(20'h00000, draw_gap());
        send_page(20'hFFFFF, draw_gap());
        send_page(20'h5A5A5, draw_gap());
        send_page(20'hA5A5A, draw_gap());
        send_page(20'h00000, draw_gap());
        send_page(20'hFFFFF, draw_gap());
        send_page(20'h12345, draw_gap());
        send_page(20'h00000, draw_gap());
        send_page(20'hFFFFF, draw_gap());
        send_page(20'h12345, draw_gap());
        send_page(20'hA5A5A, draw_gap());
        send_page(20'h80001, draw_gap());
        drain_results();

        // Grow the limit, shrink it below the filled count, then raise it past the top.
        write_frames(5'd16);
        send_page(20'h0F0F0, draw_gap());
        send_page(20'hF0F0F, draw_gap());
        drain_results();
        write_frames(5'd2);
        send_page(20'hF0F0F, draw_gap());
        drain_results();
        write_frames(5'd31);
        send_page(20'hF0F0F, draw_gap());
        drain_results();
        write_frames(5'd0);
        send_page(20'h33333, draw_gap());
        send_page(20'h44444, draw_gap());

        for (ph = 0; ph < 8; ph++)
        begin
            drain_results();
            write_frames(phase_limits[ph][4:0]);
            span = (phase_limits[ph] == 0) ? 1 : (phase_limits[ph] > 16 ? 16 : phase_limits[ph]);
            for (k = 0; k < 24; k++)
                working_set[k] = PBITS'($urandom_range(0, PAGE_MAX));
            for (it = 0; it < 80; it++)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 82)
                    pg = working_set[$urandom_range(0, span + 3)];
                else
                    pg = PBITS'($urandom_range(0, PAGE_MAX));
                if ($urandom_range(0, 15) == 0)
                    working_set[$urandom_range(0, 23)] = PBITS'($urandom_range(0, PAGE_MAX));
                if (ph % 3 == 1 || it % 40 < 8)
                    gap = 0;
                else
                    gap = draw_gap();
                send_page(pg, gap);
                if ($urandom_range(0, 49) == 0)
                    drain_results();
            end
        end
        drain_results();

        $display("Sent %0d page requests under %0d frame limit writes, from 0 up to 31.",
                 items_sent, limit_writes);
        $display("Checked %0d results: %0d hits and %0d evictions.",
                 results_checked, hit_results, evict_results);
        if (fail_total == 0 && outstanding == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
